/* hdl/lfru_weighted_replacement_top_macros.svh */
// Assertion macros for the weighted replacement tracker.
`ifndef LFRU_WEIGHTED_REPLACEMENT_TOP_MACROS_SVH
`define LFRU_WEIGHTED_REPLACEMENT_TOP_MACROS_SVH
`ifndef SYNTH
`define LFRU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LFRU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LFRU_ASSERT_IMPL(label, ante, cons)
`define LFRU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/lfru_pkg.sv */
// Shared types and constants for the weighted replacement tracker.
`default_nettype none
package lfru_pkg;
    localparam int ENTRIES       = 16;
    localparam int FRACTION_BITS = 16;
    localparam int POS_W  = $clog2(ENTRIES);
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int DIV_W  = 64 + FRACTION_BITS;
    localparam int WT_W   = 65 + FRACTION_BITS;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int TAG_W  = 20;

    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_PROBE   = 2'd1;
    localparam logic [1:0] CMD_WRITE   = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    localparam logic [31:0] PERIOD_RESET = 32'd1000;

    typedef struct packed {
        logic [TAG_W-1:0] file;
        logic [TAG_W-1:0] seg;
        logic [31:0]      hits;
        logic [31:0]      last;
    } t_entry;

    typedef struct packed {
        logic take_nbr;
        logic load;
        logic bump;
        logic restart;
    } t_cell_ctl;
endpackage
`default_nettype wire

/* hdl/lfru_cell.sv */
// One storage cell of the age-ordered entry chain.
`default_nettype none
module lfru_cell (
    input  wire logic                  i_clk,
    input  wire lfru_pkg::t_cell_ctl   i_ctl,
    input  wire lfru_pkg::t_entry      i_nbr,
    input  wire lfru_pkg::t_entry      i_new,
    input  wire logic                  i_valid,
    input  wire logic [lfru_pkg::TAG_W-1:0] i_file,
    input  wire logic [lfru_pkg::TAG_W-1:0] i_seg,
    input  wire logic                  i_any,
    output lfru_pkg::t_entry           o_entry,
    output logic                       o_sel,
    output logic                       o_any
);
    lfru_pkg::t_entry r_entry;
    logic match;

    assign match   = i_valid && (r_entry.file == i_file) && (r_entry.seg == i_seg);
    assign o_sel   = match && !i_any;
    assign o_any   = i_any || match;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_nbr) begin
            r_entry <= i_nbr;
        end else if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.bump) begin
            if (r_entry.hits != 32'hFFFF_FFFF) begin
                r_entry.hits <= r_entry.hits + 32'd1;
            end
            r_entry.last <= i_new.last;
        end else if (i_ctl.restart) begin
            r_entry.hits <= 32'd1;
        end
    end
endmodule
`default_nettype wire

/* hdl/lfru_wsel.sv */
// Shared weight unit: multiply, bit-serial divide, and keep the heaviest entry.
`default_nettype none
module lfru_wsel (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [lfru_pkg::POS_W-1:0]   i_idx,
    input  wire lfru_pkg::t_entry             i_entry,
    input  wire logic [31:0]                  i_tt,
    input  wire logic [31:0]                  i_period,
    input  wire logic [31:0]                  i_now,
    output logic                              o_done,
    output logic [lfru_pkg::POS_W-1:0]        o_best_idx,
    output logic [lfru_pkg::TAG_W-1:0]        o_best_file,
    output logic [lfru_pkg::TAG_W-1:0]        o_best_seg
);
    typedef enum logic [2:0] {U_IDLE, U_MUL, U_DIV, U_ADD, U_CMP} t_ustate;
    t_ustate r_state;

    logic [31:0] r_tr, r_pmt, r_tt, r_cnt, r_rem;
    logic [63:0] r_a;
    logic [lfru_pkg::DIV_W-1:0] r_dvd;
    logic [lfru_pkg::WT_W-1:0]  r_w, r_best;
    logic [lfru_pkg::STEP_W-1:0] r_step;
    logic [lfru_pkg::POS_W-1:0] r_idx, r_best_idx;
    logic [lfru_pkg::TAG_W-1:0] r_file, r_seg, r_best_file, r_best_seg;

    logic [32:0] rem_sh, rem_sub;
    logic        ge;

    assign rem_sh  = {r_rem, r_dvd[lfru_pkg::DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_cnt};
    assign ge      = rem_sh >= {1'b0, r_cnt};

    assign o_done      = (r_state == U_CMP);
    assign o_best_idx  = r_best_idx;
    assign o_best_file = r_best_file;
    assign o_best_seg  = r_best_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_tr   <= (i_now >= i_entry.last) ? i_now - i_entry.last : 32'd0;
                        r_pmt  <= i_period - i_tt;
                        r_tt   <= i_tt;
                        r_cnt  <= (i_entry.hits == 32'd0) ? 32'd1 : i_entry.hits;
                        r_idx  <= i_idx;
                        r_file <= i_entry.file;
                        r_seg  <= i_entry.seg;
                        r_state <= U_MUL;
                    end
                end
                U_MUL: begin
                    r_a    <= 64'(r_pmt) * 64'(r_tr);
                    r_dvd  <= lfru_pkg::DIV_W'(64'(r_tt) * 64'(r_tt))
                              << lfru_pkg::FRACTION_BITS;
                    r_rem  <= 32'd0;
                    r_step <= '0;
                    r_state <= U_DIV;
                end
                U_DIV: begin
                    // one quotient bit per cycle, shifted into the dividend
                    r_rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
                    r_dvd <= {r_dvd[lfru_pkg::DIV_W-2:0], ge};
                    r_step <= r_step + lfru_pkg::STEP_W'(1);
                    if (r_step == lfru_pkg::STEP_W'(lfru_pkg::DIV_W - 1)) begin
                        r_state <= U_ADD;
                    end
                end
                U_ADD: begin
                    r_w <= (lfru_pkg::WT_W'(r_a) << lfru_pkg::FRACTION_BITS)
                           + lfru_pkg::WT_W'(r_dvd);
                    r_state <= U_CMP;
                end
                U_CMP: begin
                    // strict greater keeps the older entry on ties
                    if (r_idx == '0 || r_w > r_best) begin
                        r_best      <= r_w;
                        r_best_idx  <= r_idx;
                        r_best_file <= r_file;
                        r_best_seg  <= r_seg;
                    end
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/lfru_weighted_replacement_top.sv */
// Top level of the weighted replacement segment tracker.
// Entries sit in a chain of cells ordered by insertion age, oldest in cell 0.
// Read, probe, restart and a write with free room are handled in the idle state.
// A write to a full chain rotates the chain once around through a shared weight
// unit (two multipliers and a one-bit-per-cycle divider), then drops the victim
// and appends the new entry once the output register is free.
`default_nettype none
`include "lfru_weighted_replacement_top_macros.svh"
module lfru_weighted_replacement_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [19:0] i_file_tag,
    input  wire logic [19:0] i_segment_tag,
    input  wire logic [31:0] i_now,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_hit,
    output logic             o_evicted_valid,
    output logic [19:0]      o_evicted_file,
    output logic [19:0]      o_evicted_segment,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_period_ticks
);
    localparam int N = lfru_pkg::ENTRIES;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EVICT} t_state;
    t_state r_state;

    logic [31:0] r_period, r_pstart, r_tt, r_now;
    logic [lfru_pkg::OCC_W-1:0] r_occ;
    logic [lfru_pkg::POS_W-1:0] r_step;
    logic r_wait;
    logic [19:0] r_file, r_seg;

    logic [31:0] n_tt;
    logic acc, full, out_free, rotate, evict_go, wdone, is_write;
    lfru_pkg::t_entry new_ent, last_nbr;
    lfru_pkg::t_entry ent [N];
    lfru_pkg::t_cell_ctl ctl [N];
    logic [N-1:0] sel, cvalid;
    logic [N:0] any;
    logic [lfru_pkg::POS_W-1:0] best_idx;
    logic [19:0] best_file, best_seg;

    assign o_cfg_ready = 1'b1;
    assign full      = (r_occ == lfru_pkg::OCC_W'(N));
    assign out_free  = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign acc       = i_in_valid && !o_in_stall;
    assign is_write  = (i_command == lfru_pkg::CMD_WRITE);
    assign rotate    = (r_state == S_SCAN) && !r_wait;
    assign evict_go  = (r_state == S_EVICT) && out_free;
    assign last_nbr  = rotate ? ent[0] : new_ent;
    assign any[0]    = 1'b0;

    always_comb begin
        if (r_state == S_EVICT) begin
            new_ent = '{file: r_file, seg: r_seg, hits: 32'd1, last: r_now};
        end else begin
            new_ent = '{file: i_file_tag, seg: i_segment_tag, hits: 32'd1, last: i_now};
        end
        n_tt = (i_now >= r_pstart) ? i_now - r_pstart : 32'd0;
        if (n_tt > r_period) begin
            n_tt = r_period;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        lfru_pkg::t_entry nbr;
        assign cvalid[g] = (lfru_pkg::OCC_W'(g) < r_occ);
        assign nbr = (g == N - 1) ? last_nbr : ent[(g + 1) % N];
        always_comb begin
            ctl[g].take_nbr = rotate || (evict_go && (lfru_pkg::POS_W'(g) >= best_idx));
            ctl[g].load     = acc && is_write && !full && (r_occ == lfru_pkg::OCC_W'(g));
            ctl[g].bump     = acc && (i_command == lfru_pkg::CMD_READ) && sel[g];
            ctl[g].restart  = acc && (i_command == lfru_pkg::CMD_RESTART);
        end
        lfru_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl[g]),
            .i_nbr   (nbr),
            .i_new   (new_ent),
            .i_valid (cvalid[g]),
            .i_file  (i_file_tag),
            .i_seg   (i_segment_tag),
            .i_any   (any[g]),
            .o_entry (ent[g]),
            .o_sel   (sel[g]),
            .o_any   (any[g+1])
        );
    end

    lfru_wsel u_wsel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (rotate),
        .i_idx       (r_step),
        .i_entry     (ent[0]),
        .i_tt        (r_tt),
        .i_period    (r_period),
        .i_now       (r_now),
        .o_done      (wdone),
        .o_best_idx  (best_idx),
        .o_best_file (best_file),
        .o_best_seg  (best_seg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= lfru_pkg::PERIOD_RESET;
            r_pstart    <= 32'd0;
            r_occ       <= '0;
            r_wait      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_period <= i_cfg_period_ticks;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc && is_write && full) begin
                        r_file  <= i_file_tag;
                        r_seg   <= i_segment_tag;
                        r_now   <= i_now;
                        r_tt    <= n_tt;
                        r_step  <= '0;
                        r_wait  <= 1'b0;
                        r_state <= S_SCAN;
                    end else if (acc) begin
                        if (is_write) begin
                            r_occ <= r_occ + lfru_pkg::OCC_W'(1);
                        end
                        if (i_command == lfru_pkg::CMD_RESTART) begin
                            r_pstart <= i_now;
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (wdone) begin
                        r_wait <= 1'b0;
                        if (r_step == lfru_pkg::POS_W'(N - 1)) begin
                            r_state <= S_EVICT;
                        end else begin
                            r_step <= r_step + lfru_pkg::POS_W'(1);
                        end
                    end
                end
                S_EVICT: begin
                    if (evict_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // output register: hold until taken
            if (acc && !(is_write && full)) begin
                o_out_valid       <= 1'b1;
                o_hit             <= (i_command == lfru_pkg::CMD_READ ||
                                      i_command == lfru_pkg::CMD_PROBE) && any[N];
                o_evicted_valid   <= 1'b0;
                o_evicted_file    <= 20'd0;
                o_evicted_segment <= 20'd0;
            end else if (evict_go) begin
                o_out_valid       <= 1'b1;
                o_hit             <= 1'b0;
                o_evicted_valid   <= 1'b1;
                o_evicted_file    <= best_file;
                o_evicted_segment <= best_seg;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    `LFRU_ASSERT_IMPL(a_scan_full, r_state != S_IDLE, full)
    `LFRU_ASSERT_IMPL(a_occ_range, 1'b1, r_occ <= lfru_pkg::OCC_W'(N))
    `LFRU_ASSERT_NEXT(a_full_write, acc && is_write && full, r_state == S_SCAN)
    `LFRU_ASSERT_IMPL(a_one_kind, o_out_valid, !(o_hit && o_evicted_valid))
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Testbench for the weighted replacement segment tracker: random and directed requests.
`timescale 1ns / 1ps
module testbench;

    typedef struct packed {
        logic        hit;
        logic        ev_valid;
        logic [19:0] ev_file;
        logic [19:0] ev_seg;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [19:0] i_file_tag;
    logic [19:0] i_segment_tag;
    logic [31:0] i_now;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_hit;
    logic        o_evicted_valid;
    logic [19:0] o_evicted_file;
    logic [19:0] o_evicted_segment;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_period_ticks;

    lfru_weighted_replacement_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_file_tag         (i_file_tag),
        .i_segment_tag      (i_segment_tag),
        .i_now              (i_now),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hit              (o_hit),
        .o_evicted_valid    (o_evicted_valid),
        .o_evicted_file     (o_evicted_file),
        .o_evicted_segment  (o_evicted_segment),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_period_ticks (i_cfg_period_ticks)
    );

    // tracker mirror
    logic [19:0] trk_file [lfru_pkg::ENTRIES];
    logic [19:0] trk_seg  [lfru_pkg::ENTRIES];
    logic [31:0] trk_hits [lfru_pkg::ENTRIES];
    logic [31:0] trk_last [lfru_pkg::ENTRIES];
    logic [3:0]  trk_rank [lfru_pkg::ENTRIES];
    int unsigned trk_fill;
    logic [31:0] trk_period_start;
    logic [31:0] trk_period;

    t_outcome    pending_outcomes[$];
    int unsigned fail_count;
    logic        quiet;
    logic [31:0] clock_ticks;
    logic [19:0] tag_pool [6];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("testbench NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 38);
    end

    // check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result hit=%b ev=%b file=%h seg=%h", $time,
                         o_hit, o_evicted_valid, o_evicted_file, o_evicted_segment);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, o_hit);
                    fail_count++;
                end
                if (o_evicted_valid !== want.ev_valid) begin
                    $display("%0t: evicted_valid expected %b actual %b", $time,
                             want.ev_valid, o_evicted_valid);
                    fail_count++;
                end
                if (o_evicted_file !== want.ev_file) begin
                    $display("%0t: evicted_file expected %h actual %h", $time,
                             want.ev_file, o_evicted_file);
                    fail_count++;
                end
                if (o_evicted_segment !== want.ev_seg) begin
                    $display("%0t: evicted_segment expected %h actual %h", $time,
                             want.ev_seg, o_evicted_segment);
                    fail_count++;
                end
            end
        end
    end

    // weight as {carry, whole, fraction}
    function automatic logic [80:0] slot_weight(int slot, logic [31:0] tt, logic [31:0] now);
        logic [31:0] tr;
        logic [63:0] cnt, prod, sq, quo, rem, frac;
        logic [64:0] sum;
        tr   = (now >= trk_last[slot]) ? now - trk_last[slot] : 32'd0;
        cnt  = (trk_hits[slot] != 0) ? {32'd0, trk_hits[slot]} : 64'd1;
        prod = {32'd0, trk_period - tt} * {32'd0, tr};
        sq   = {32'd0, tt} * {32'd0, tt};
        quo  = sq / cnt;
        rem  = sq % cnt;
        frac = (rem << lfru_pkg::FRACTION_BITS) / cnt;
        sum  = {1'b0, prod} + {1'b0, quo};
        return {sum, frac[15:0]};
    endfunction

    function automatic t_outcome track_request(logic [1:0] cmd, logic [19:0] f,
                                               logic [19:0] s, logic [31:0] now);
        t_outcome res;
        int m;
        logic [31:0] tt;
        logic [80:0] best, w;
        int victim;
        logic [3:0] vrank;
        res = '0;
        m = -1;
        if (cmd == lfru_pkg::CMD_READ || cmd == lfru_pkg::CMD_PROBE) begin
            for (int i = 0; i < trk_fill; i++)
                if (trk_file[i] == f && trk_seg[i] == s && (m < 0 || trk_rank[i] < trk_rank[m]))
                    m = i;
            if (m >= 0) begin
                res.hit = 1'b1;
                if (cmd == lfru_pkg::CMD_READ) begin
                    if (trk_hits[m] != 32'hFFFF_FFFF) trk_hits[m]++;
                    trk_last[m] = now;
                end
            end
        end else if (cmd == lfru_pkg::CMD_RESTART) begin
            for (int i = 0; i < trk_fill; i++) trk_hits[i] = 32'd1;
            trk_period_start = now;
        end else if (trk_fill < lfru_pkg::ENTRIES) begin
            trk_file[trk_fill] = f;
            trk_seg[trk_fill]  = s;
            trk_hits[trk_fill] = 32'd1;
            trk_last[trk_fill] = now;
            trk_rank[trk_fill] = trk_fill[3:0];
            trk_fill++;
        end else begin
            tt = (now >= trk_period_start) ? now - trk_period_start : 32'd0;
            if (tt > trk_period) tt = trk_period;
            victim = 0;
            vrank  = '0;
            best   = '0;
            for (int i = lfru_pkg::ENTRIES - 1; i >= 0; i--)
                if (trk_rank[i] == 0) victim = i;
            for (int i = 0; i < lfru_pkg::ENTRIES; i++) begin
                w = slot_weight(i, tt, now);
                if (w > best || (w == best && trk_rank[i] < vrank)) begin
                    best   = w;
                    victim = i;
                    vrank  = trk_rank[i];
                end
            end
            vrank = trk_rank[victim];
            res.ev_valid = 1'b1;
            res.ev_file  = trk_file[victim];
            res.ev_seg   = trk_seg[victim];
            for (int i = 0; i < lfru_pkg::ENTRIES; i++)
                if (trk_rank[i] > vrank) trk_rank[i]--;
            trk_file[victim] = f;
            trk_seg[victim]  = s;
            trk_hits[victim] = 32'd1;
            trk_last[victim] = now;
            trk_rank[victim] = 4'(lfru_pkg::ENTRIES - 1);
        end
        return res;
    endfunction

    task automatic send_request(logic [1:0] cmd, logic [19:0] f, logic [19:0] s,
                                logic [31:0] now);
        if (!quiet && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_file_tag    <= f;
        i_segment_tag <= s;
        i_now         <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_outcomes = {pending_outcomes, track_request(cmd, f, s, now)};
    endtask

    // hold off until every outstanding result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_period(logic [31:0] value);
        drain_results();
        i_cfg_valid        <= 1'b1;
        i_cfg_period_ticks <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        trk_period = value;
    endtask

    function automatic logic [19:0] pick_tag();
        return ($urandom_range(99) < 75) ? tag_pool[$urandom_range(5)] : 20'($urandom);
    endfunction

    task automatic test_directed();
        // fill with extreme tags and times
        send_request(lfru_pkg::CMD_WRITE, 20'h00000, 20'h00000, 32'd0);
        send_request(lfru_pkg::CMD_WRITE, 20'hFFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
        send_request(lfru_pkg::CMD_READ,  20'hFFFFF, 20'hFFFFF, 32'd5);
        send_request(lfru_pkg::CMD_PROBE, 20'h00000, 20'h00000, 32'd6);
        send_request(lfru_pkg::CMD_READ,  20'h12345, 20'h00000, 32'd7);
        send_request(lfru_pkg::CMD_PROBE, 20'h00000, 20'hFFFFF, 32'd8);
        for (int i = 2; i < lfru_pkg::ENTRIES; i++)
            send_request(lfru_pkg::CMD_WRITE, 20'(i), 20'(i * 3), 32'(10 * i));
        // duplicate tag inserted while full, then a read picks the oldest copy
        send_request(lfru_pkg::CMD_WRITE, 20'd4, 20'd12, 32'd200);
        send_request(lfru_pkg::CMD_READ,  20'd4, 20'd12, 32'd210);
        send_request(lfru_pkg::CMD_RESTART, 20'hABCDE, 20'h54321, 32'd300);
        // now below the period start and below the last hit
        send_request(lfru_pkg::CMD_WRITE, 20'hFFFFF, 20'h00001, 32'd100);
        send_request(lfru_pkg::CMD_WRITE, 20'h0F0F0, 20'hF0F0F, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_random(int n, int quiet_from, int quiet_to);
        logic [1:0] cmd;
        logic [31:0] now;
        int roll;
        for (int k = 0; k < n; k++) begin
            quiet = (k >= quiet_from && k < quiet_to);
            roll = $urandom_range(99);
            cmd = (roll < 42) ? lfru_pkg::CMD_READ : (roll < 64) ? lfru_pkg::CMD_PROBE :
                  (roll < 94) ? lfru_pkg::CMD_WRITE : lfru_pkg::CMD_RESTART;
            // keep evicting writes rare, each one costs a full chain pass
            if (cmd == lfru_pkg::CMD_WRITE && trk_fill == lfru_pkg::ENTRIES &&
                $urandom_range(99) < 30)
                cmd = lfru_pkg::CMD_READ;
            clock_ticks += $urandom_range(0, 60);
            roll = $urandom_range(99);
            now = (roll < 8) ? $urandom : (roll < 12) ? clock_ticks - $urandom_range(0, 500)
                                                      : clock_ticks;
            send_request(cmd, pick_tag(), pick_tag(), now);
        end
        quiet = 1'b0;
    endtask

    initial begin
        fail_count         = 0;
        quiet              = 1'b0;
        clock_ticks        = 32'd0;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_command          = lfru_pkg::CMD_READ;
        i_file_tag         = '0;
        i_segment_tag      = '0;
        i_now              = '0;
        i_out_stall        = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_period_ticks = '0;
        trk_fill           = 0;
        trk_period_start   = '0;
        trk_period         = lfru_pkg::PERIOD_RESET;
        for (int i = 0; i < 6; i++) tag_pool[i] = 20'($urandom_range(0, 3));
        tag_pool[4] = 20'hFFFFF;
        tag_pool[5] = 20'($urandom);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(500, 150, 350);
        write_period(32'd1);
        test_random(350, 1000, 1000);
        write_period(32'hFFFF_FFFF);
        test_directed();
        test_random(350, 1000, 1000);
        write_period($urandom_range(50, 5000));
        test_random(350, 1000, 1000);
        write_period(lfru_pkg::PERIOD_RESET);
        test_random(350, 0, 50);
        drain_results();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
